// ===== rtl/core/lfl_pkg.sv =====
// types, constants and segment table for the lux pipeline
package lfl_pkg;

  localparam int CHANNEL_BITS   = 16;
  localparam int SCALE_BITS     = 19;
  localparam int PROD_BITS      = CHANNEL_BITS + SCALE_BITS;
  localparam int FRAC_SCALE     = 10;
  localparam int SCALED_BITS    = 22;
  localparam int REM_BITS       = SCALED_BITS + 2;
  localparam int QUOT_BITS      = 12;
  localparam int COEF_BITS      = 10;
  localparam int ACC_BITS       = 32;
  localparam int LUX_SHIFT      = 14;
  localparam int LUX_BITS       = 17;
  localparam int NUM_SEG        = 7;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_INTEG   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN    = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PACKAGE = 2'd2;

  localparam logic [1:0] INTEG_13MS  = 2'd0;
  localparam logic [1:0] INTEG_101MS = 2'd1;
  localparam logic [1:0] INTEG_402MS = 2'd2;

  localparam logic [CHANNEL_BITS-1:0] LIMIT_13MS  = 16'd4900;
  localparam logic [CHANNEL_BITS-1:0] LIMIT_101MS = 16'd37000;
  localparam logic [CHANNEL_BITS-1:0] LIMIT_402MS = 16'd65000;

  localparam logic [SCALE_BITS-1:0] SCALE_13MS  = 19'h07517;
  localparam logic [SCALE_BITS-1:0] SCALE_101MS = 19'h00FE7;
  localparam logic [SCALE_BITS-1:0] SCALE_402MS = 19'h00400;

  localparam logic [ACC_BITS:0] ROUND_HALF = (ACC_BITS+1)'(1) << (LUX_SHIFT - 1);

  localparam logic [COEF_BITS-1:0] SEG_T_BP [NUM_SEG] =
    '{10'h040, 10'h080, 10'h0C0, 10'h100, 10'h138, 10'h19A, 10'h29A};
  localparam logic [COEF_BITS-1:0] SEG_T_B [NUM_SEG] =
    '{10'h1F2, 10'h214, 10'h23F, 10'h270, 10'h16F, 10'h0D2, 10'h018};
  localparam logic [COEF_BITS-1:0] SEG_T_M [NUM_SEG] =
    '{10'h1BE, 10'h2D1, 10'h37B, 10'h3FE, 10'h1FC, 10'h0FB, 10'h012};
  localparam logic [COEF_BITS-1:0] SEG_CS_BP [NUM_SEG] =
    '{10'h043, 10'h085, 10'h0C8, 10'h10A, 10'h14D, 10'h19A, 10'h29A};
  localparam logic [COEF_BITS-1:0] SEG_CS_B [NUM_SEG] =
    '{10'h204, 10'h228, 10'h253, 10'h282, 10'h177, 10'h101, 10'h037};
  localparam logic [COEF_BITS-1:0] SEG_CS_M [NUM_SEG] =
    '{10'h1AD, 10'h2C1, 10'h363, 10'h3DF, 10'h1DD, 10'h127, 10'h02B};

  typedef struct packed {
    logic [SCALED_BITS-1:0] s0;
    logic [SCALED_BITS-1:0] s1;
    logic                   clip;
    logic                   zero;
    logic                   sat;
    logic                   pkg_cs;
  } lfl_side_t;

  typedef struct packed {
    logic [COEF_BITS-1:0] b;
    logic [COEF_BITS-1:0] m;
  } lfl_coef_t;

  // first segment whose breakpoint is not below the ratio
  function automatic lfl_coef_t lfl_seg(input logic cs, input logic [QUOT_BITS-1:0] ratio);
    lfl_coef_t res;
    logic [COEF_BITS-1:0] bp;
    res = '0;
    for (int k = NUM_SEG - 1; k >= 0; k--) begin
      bp = cs ? SEG_CS_BP[k] : SEG_T_BP[k];
      if (ratio <= QUOT_BITS'(bp)) begin
        res.b = cs ? SEG_CS_B[k] : SEG_T_B[k];
        res.m = cs ? SEG_CS_M[k] : SEG_T_M[k];
      end
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/lfl_ifs.sv =====
// request channel interfaces for counts, lux and register writes
interface lfl_in_if;
  logic                             valid;
  logic                             ready;
  logic [lfl_pkg::CHANNEL_BITS-1:0] broadband_count;
  logic [lfl_pkg::CHANNEL_BITS-1:0] infrared_count;
  modport source (output valid, output broadband_count, output infrared_count, input ready);
  modport sink (input valid, input broadband_count, input infrared_count, output ready);
endinterface

interface lfl_out_if;
  logic                         valid;
  logic                         ready;
  logic [lfl_pkg::LUX_BITS-1:0] lux;
  modport source (output valid, output lux, input ready);
  modport sink (input valid, input lux, output ready);
endinterface

interface lfl_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [lfl_pkg::CFG_INDEX_BITS-1:0] index;
  logic [lfl_pkg::CFG_DATA_BITS-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/lux_from_light_channels.sv =====
// lux from broadband and infrared counts, eighteen-stage pipeline
//
//   channel  dir  payload                           accepted when
//   light_i  in   broadband_count, infrared_count   valid & ready
//   lux_o    out  lux                               valid & ready
//   cfg_i    in   index, data                       valid & ready (always ready)
//
// one request per cycle sustained while lux_o does not stall
// stages: clip and scale select, scaling multiply, divider setup,
// twelve divider stages of one quotient bit each, segment lookup,
// coefficient multiply, round and output register
// ready runs back stage by stage, so empty stages fill while the output waits
// reset empties the pipe and loads integration 402 ms, 1x gain, T coefficients
module lux_from_light_channels (
  input  logic          clk_i,
  input  logic          rst_ni,
  lfl_in_if.sink        light_i,
  lfl_out_if.source     lux_o,
  lfl_cfg_if.sink       cfg_i
);

  logic [1:0] integ_q;
  logic       gain_q;
  logic       pkg_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= lfl_pkg::INTEG_402MS;
      gain_q  <= 1'b0;
      pkg_q   <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        lfl_pkg::REG_INTEG:   integ_q <= cfg_i.data[1:0];
        lfl_pkg::REG_GAIN:    gain_q  <= cfg_i.data[0];
        lfl_pkg::REG_PACKAGE: pkg_q   <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // stage a: threshold and scale
  logic [lfl_pkg::CHANNEL_BITS-1:0] limit;
  logic [lfl_pkg::SCALE_BITS-1:0]   scale_base;
  logic [lfl_pkg::SCALE_BITS-1:0]   scale;

  always_comb begin
    case (integ_q)
      lfl_pkg::INTEG_13MS: begin
        limit      = lfl_pkg::LIMIT_13MS;
        scale_base = lfl_pkg::SCALE_13MS;
      end
      lfl_pkg::INTEG_101MS: begin
        limit      = lfl_pkg::LIMIT_101MS;
        scale_base = lfl_pkg::SCALE_101MS;
      end
      default: begin
        limit      = lfl_pkg::LIMIT_402MS;
        scale_base = lfl_pkg::SCALE_402MS;
      end
    endcase
    scale = gain_q ? scale_base : (scale_base << 4);
  end

  logic a_vld_q, b_vld_q, c_vld_q, e_vld_q, f_vld_q, g_vld_q;
  logic a_rdy, b_rdy, c_rdy, e_rdy, f_rdy, g_rdy;
  logic div_in_rdy, div_out_vld;

  logic [lfl_pkg::CHANNEL_BITS-1:0] a_c0_q, a_c1_q;
  logic [lfl_pkg::SCALE_BITS-1:0]   a_scale_q;
  logic                             a_clip_q, a_pkg_q;

  logic [lfl_pkg::SCALED_BITS-1:0]  b_s0_q, b_s1_q;
  logic                             b_clip_q, b_pkg_q;

  lfl_pkg::lfl_side_t               c_side_q;
  lfl_pkg::lfl_side_t               div_side;
  logic [lfl_pkg::QUOT_BITS-1:0]    div_quot;

  logic [lfl_pkg::SCALED_BITS-1:0]  e_s0_q, e_s1_q;
  lfl_pkg::lfl_coef_t               e_coef_q;
  logic                             e_clip_q;

  logic [lfl_pkg::ACC_BITS-1:0]     f_pos_q, f_neg_q;
  logic                             f_clip_q;

  logic [lfl_pkg::LUX_BITS-1:0]     g_lux_q;

  assign g_rdy = !g_vld_q || lux_o.ready;
  assign f_rdy = !f_vld_q || g_rdy;
  assign e_rdy = !e_vld_q || f_rdy;
  assign c_rdy = !c_vld_q || div_in_rdy;
  assign b_rdy = !b_vld_q || c_rdy;
  assign a_rdy = !a_vld_q || b_rdy;

  assign light_i.ready = a_rdy;
  assign lux_o.valid   = g_vld_q;
  assign lux_o.lux     = g_lux_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
      f_vld_q <= 1'b0;
      g_vld_q <= 1'b0;
    end else begin
      if (a_rdy) a_vld_q <= light_i.valid;
      if (b_rdy) b_vld_q <= a_vld_q;
      if (c_rdy) c_vld_q <= b_vld_q;
      if (e_rdy) e_vld_q <= div_out_vld;
      if (f_rdy) f_vld_q <= e_vld_q;
      if (g_rdy) g_vld_q <= f_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy) begin
      a_c0_q    <= light_i.broadband_count;
      a_c1_q    <= light_i.infrared_count;
      a_scale_q <= scale;
      a_clip_q  <= (light_i.broadband_count > limit) || (light_i.infrared_count > limit);
      a_pkg_q   <= pkg_q;
    end
  end

  // stage b: scale to nominal integration and gain
  logic [lfl_pkg::PROD_BITS-1:0] prod0, prod1;

  assign prod0 = lfl_pkg::PROD_BITS'(a_c0_q) * lfl_pkg::PROD_BITS'(a_scale_q);
  assign prod1 = lfl_pkg::PROD_BITS'(a_c1_q) * lfl_pkg::PROD_BITS'(a_scale_q);

  always_ff @(posedge clk_i) begin
    if (b_rdy) begin
      b_s0_q   <= prod0[lfl_pkg::FRAC_SCALE +: lfl_pkg::SCALED_BITS];
      b_s1_q   <= prod1[lfl_pkg::FRAC_SCALE +: lfl_pkg::SCALED_BITS];
      b_clip_q <= a_clip_q;
      b_pkg_q  <= a_pkg_q;
    end
  end

  // stage c: quotient overflow and zero divisor
  always_ff @(posedge clk_i) begin
    if (c_rdy) begin
      c_side_q.s0     <= b_s0_q;
      c_side_q.s1     <= b_s1_q;
      c_side_q.clip   <= b_clip_q;
      c_side_q.zero   <= (b_s0_q == '0);
      c_side_q.sat    <= (lfl_pkg::REM_BITS'(b_s1_q) >= {b_s0_q, 2'b00});
      c_side_q.pkg_cs <= b_pkg_q;
    end
  end

  lfl_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (c_vld_q),
    .in_ready_o  (div_in_rdy),
    .in_side_i   (c_side_q),
    .out_valid_o (div_out_vld),
    .out_ready_i (e_rdy),
    .out_side_o  (div_side),
    .out_quot_o  (div_quot)
  );

  // stage e: rounded ratio and segment lookup
  logic [lfl_pkg::QUOT_BITS:0]   quot_inc;
  logic [lfl_pkg::QUOT_BITS-1:0] ratio;
  lfl_pkg::lfl_coef_t            coef;

  assign quot_inc = {1'b0, div_quot} + (lfl_pkg::QUOT_BITS+1)'(1);

  always_comb begin
    ratio = div_side.zero ? '0 : quot_inc[lfl_pkg::QUOT_BITS:1];
    coef  = lfl_pkg::lfl_seg(div_side.pkg_cs, ratio);
    if (div_side.sat && !div_side.zero) begin
      coef = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_rdy) begin
      e_s0_q   <= div_side.s0;
      e_s1_q   <= div_side.s1;
      e_coef_q <= coef;
      e_clip_q <= div_side.clip;
    end
  end

  // stage f: offset and slope products
  always_ff @(posedge clk_i) begin
    if (f_rdy) begin
      f_pos_q  <= lfl_pkg::ACC_BITS'(e_s0_q) * lfl_pkg::ACC_BITS'(e_coef_q.b);
      f_neg_q  <= lfl_pkg::ACC_BITS'(e_s1_q) * lfl_pkg::ACC_BITS'(e_coef_q.m);
      f_clip_q <= e_clip_q;
    end
  end

  // stage g: clamp, round, shift
  logic [lfl_pkg::ACC_BITS-1:0] diff;
  logic [lfl_pkg::ACC_BITS:0]   rnd;

  assign diff = (f_pos_q > f_neg_q) ? (f_pos_q - f_neg_q) : '0;
  assign rnd  = {1'b0, diff} + lfl_pkg::ROUND_HALF;

  always_ff @(posedge clk_i) begin
    if (g_rdy) begin
      g_lux_q <= f_clip_q ? '0 : rnd[lfl_pkg::LUX_SHIFT +: lfl_pkg::LUX_BITS];
    end
  end

endmodule

// ===== rtl/core/lfl_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module lfl_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  lfl_pkg::lfl_side_t              in_side_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output lfl_pkg::lfl_side_t              out_side_o,
  output logic [lfl_pkg::QUOT_BITS-1:0]   out_quot_o
);

  localparam int Steps = lfl_pkg::QUOT_BITS;
  localparam int RemW  = lfl_pkg::REM_BITS;

  logic                  vld_q  [Steps];
  logic [RemW-1:0]       rem_q  [Steps];
  logic [Steps-1:0]      quot_q [Steps];
  lfl_pkg::lfl_side_t    side_q [Steps];
  logic                  rdy    [Steps];

  logic                  vld_in  [Steps];
  logic [RemW-1:0]       rem_in  [Steps];
  logic [Steps-1:0]      quot_in [Steps];
  lfl_pkg::lfl_side_t    side_in [Steps];
  logic [RemW-1:0]       rem_d   [Steps];
  logic [Steps-1:0]      quot_d  [Steps];

  always_comb begin
    rdy[Steps-1] = !vld_q[Steps-1] || out_ready_i;
    for (int k = Steps - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[Steps-1];
  assign out_side_o  = side_q[Steps-1];
  assign out_quot_o  = quot_q[Steps-1];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [RemW:0] shl;
    logic [RemW:0] dvs;
    logic [RemW:0] dif;
    logic          ge;

    if (k == 0) begin : g_first
      assign vld_in[k]  = in_valid_i;
      assign rem_in[k]  = RemW'(in_side_i.s1);
      assign quot_in[k] = '0;
      assign side_in[k] = in_side_i;
    end else begin : g_next
      assign vld_in[k]  = vld_q[k-1];
      assign rem_in[k]  = rem_q[k-1];
      assign quot_in[k] = quot_q[k-1];
      assign side_in[k] = side_q[k-1];
    end

    assign shl       = {rem_in[k], 1'b0};
    assign dvs       = {1'b0, side_in[k].s0, 2'b00};
    assign ge        = (shl >= dvs);
    assign dif       = shl - dvs;
    assign rem_d[k]  = ge ? dif[RemW-1:0] : shl[RemW-1:0];
    assign quot_d[k] = {quot_in[k][Steps-2:0], ge};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= vld_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        rem_q[k]  <= rem_d[k];
        quot_q[k] <= quot_d[k];
        side_q[k] <= side_in[k];
      end
    end
  end

endmodule

// ===== rtl/core/lfl_checker.sv =====
// port-level checks for the lux pipeline, bound to the top level
module lfl_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [lfl_pkg::LUX_BITS-1:0] out_lux_i
);

  localparam logic [4:0] Depth = 5'd18;

  logic [4:0] inflight_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (in_acc && !out_acc) begin
      inflight_q <= inflight_q + 5'd1;
    end else if (out_acc && !in_acc) begin
      inflight_q <= inflight_q - 5'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_lux_i))
    else $error("lux request changed while stalled");

  a_full_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without an output stall");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> inflight_q != 5'd0)
    else $error("lux request with no counts in flight");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= Depth)
    else $error("more requests in flight than pipeline stages");

endmodule

bind lux_from_light_channels lfl_checker u_lfl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (light_i.valid),
  .in_ready_i  (light_i.ready),
  .out_valid_i (lux_o.valid),
  .out_ready_i (lux_o.ready),
  .out_lux_i   (lux_o.lux)
);

// ===== sim/tb_lux_from_light_channels.sv =====
// testbench for lux_from_light_channels: random counts checked against a lux predictor
typedef struct packed {
  logic [15:0] broadband;
  logic [15:0] infrared;
} counts_t;

typedef struct packed {
  counts_t     counts;
  logic [16:0] lux;
} lux_entry_t;

class lux_scoreboard;
  bit [1:0]   integ_sel;
  bit         gain_high;
  bit         package_cs;
  lux_entry_t pending_lux[$];
  int         errors;

  // breakpoint, offset and slope per segment, T package first
  bit [9:0] seg_bp [2][7] = '{'{10'h040, 10'h080, 10'h0C0, 10'h100, 10'h138, 10'h19A, 10'h29A},
                              '{10'h043, 10'h085, 10'h0C8, 10'h10A, 10'h14D, 10'h19A, 10'h29A}};
  bit [9:0] seg_b [2][7]  = '{'{10'h1F2, 10'h214, 10'h23F, 10'h270, 10'h16F, 10'h0D2, 10'h018},
                              '{10'h204, 10'h228, 10'h253, 10'h282, 10'h177, 10'h101, 10'h037}};
  bit [9:0] seg_m [2][7]  = '{'{10'h1BE, 10'h2D1, 10'h37B, 10'h3FE, 10'h1FC, 10'h0FB, 10'h012},
                              '{10'h1AD, 10'h2C1, 10'h363, 10'h3DF, 10'h1DD, 10'h127, 10'h02B}};

  function new();
    integ_sel  = lfl_pkg::INTEG_402MS;
    gain_high  = 1'b0;
    package_cs = 1'b0;
    errors     = 0;
  endfunction

  function void set_reg(logic [1:0] index, logic [1:0] data);
    case (index)
      lfl_pkg::REG_INTEG:   integ_sel = data;
      lfl_pkg::REG_GAIN:    gain_high = data[0];
      lfl_pkg::REG_PACKAGE: package_cs = data[0];
      default: ;
    endcase
  endfunction

  function bit [15:0] clip_limit();
    case (integ_sel)
      lfl_pkg::INTEG_13MS:  return 16'd4900;
      lfl_pkg::INTEG_101MS: return 16'd37000;
      default:              return 16'd65000;
    endcase
  endfunction

  function bit [16:0] predict_lux(bit [15:0] c0, bit [15:0] c1);
    bit [22:0] scale;
    bit [41:0] p0, p1;
    bit [21:0] s0, s1;
    bit [32:0] quot, ratio, pos, neg, diff;
    bit [9:0]  b, m;
    bit        found;
    if (c0 > clip_limit() || c1 > clip_limit()) return 17'd0;
    case (integ_sel)
      lfl_pkg::INTEG_13MS:  scale = 23'h07517;
      lfl_pkg::INTEG_101MS: scale = 23'h00FE7;
      default:              scale = 23'h00400;
    endcase
    if (!gain_high) scale = scale << 4;
    p0 = c0 * scale;
    p1 = c1 * scale;
    s0 = p0[31:10];
    s1 = p1[31:10];
    quot = (s0 != 0) ? ({1'b0, s1, 10'b0} / s0) : 33'd0;
    ratio = (quot + 33'd1) >> 1;
    b = '0;
    m = '0;
    found = 1'b0;
    for (int k = 0; k < 7; k++) begin
      if (!found && ratio <= seg_bp[package_cs][k]) begin
        b = seg_b[package_cs][k];
        m = seg_m[package_cs][k];
        found = 1'b1;
      end
    end
    pos = s0 * b;
    neg = s1 * m;
    diff = (pos > neg) ? pos - neg : 33'd0;
    diff = diff + 33'd8192;
    return diff[30:14];
  endfunction

  function void note_counts(counts_t req);
    lux_entry_t e;
    e.counts = req;
    e.lux = predict_lux(req.broadband, req.infrared);
    pending_lux.push_back(e);
  endfunction

  function void check_lux(logic [16:0] lux);
    lux_entry_t e;
    if (pending_lux.size() == 0) begin
      $display("%0t: unexpected lux request, actual %0d", $realtime, lux);
      errors++;
    end else begin
      e = pending_lux.pop_front();
      if (lux !== e.lux) begin
        $display("%0t: lux for broadband %0d infrared %0d expected %0d actual %0d",
                 $realtime, e.counts.broadband, e.counts.infrared, e.lux, lux);
        errors++;
      end
    end
  endfunction
endclass

module tb_lux_from_light_channels;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_CYCLES = 4000;
  localparam int PHASES          = 10;
  localparam int PHASE_ITEMS     = 93;

  logic clk_i;
  logic rst_ni;
  int   stall_cycles = 0;

  lux_scoreboard sb;

  lfl_in_if  light_if ();
  lfl_out_if lux_if ();
  lfl_cfg_if cfg_if ();

  lux_from_light_channels dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .light_i(light_if),
    .lux_o  (lux_if),
    .cfg_i  (cfg_if)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (light_if.valid && light_if.ready)
        sb.note_counts('{broadband: light_if.broadband_count, infrared: light_if.infrared_count});
      if (lux_if.valid && lux_if.ready) sb.check_lux(lux_if.lux);
      if (cfg_if.valid && cfg_if.ready) sb.set_reg(cfg_if.index, cfg_if.data);
      if ((light_if.valid && light_if.ready) || (lux_if.valid && lux_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_CYCLES) begin
        $display("lux_from_light_channels: mismatch");
        $finish;
      end
    end
  end

  // receiver stall pattern
  initial begin
    int mode, len, period;
    lux_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      len = $urandom_range(16, 80);
      period = $urandom_range(1, 6);
      for (int n = 0; n < len; n++) begin
        @(negedge clk_i);
        case (mode)
          0: lux_if.ready <= 1'b1;
          1: lux_if.ready <= 1'($urandom_range(0, 1));
          2: lux_if.ready <= ($urandom_range(0, 3) == 0);
          default: lux_if.ready <= ((n / period) % 2 == 0);
        endcase
      end
    end
  end

  task automatic push_counts(bit [15:0] c0, bit [15:0] c1);
    @(negedge clk_i);
    light_if.valid <= 1'b1;
    light_if.broadband_count <= c0;
    light_if.infrared_count <= c1;
    do @(posedge clk_i); while (!light_if.ready);
  endtask

  task automatic pause_light(int n);
    repeat (n) begin
      @(negedge clk_i);
      light_if.valid <= 1'b0;
    end
  endtask

  task automatic drain_lux();
    pause_light(1);
    while (sb.pending_lux.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] index, logic [1:0] data);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  task automatic program_regs(logic [1:0] integ, logic [1:0] gain, logic [1:0] pkg);
    write_reg(lfl_pkg::REG_INTEG, integ);
    write_reg(lfl_pkg::REG_GAIN, gain);
    write_reg(lfl_pkg::REG_PACKAGE, pkg);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic counts_t random_counts();
    counts_t   r;
    bit [15:0] lim;
    int        k;
    int        ratio;
    lim = sb.clip_limit();
    case ($urandom_range(0, 9))
      0: begin
        r.broadband = 16'($urandom());
        r.infrared = 16'($urandom());
      end
      1: begin
        r.broadband = 16'(lim - 2 + $urandom_range(0, 4));
        r.infrared = ($urandom_range(0, 1)) ? 16'(lim - 2 + $urandom_range(0, 4)) :
                                              16'($urandom_range(0, lim));
      end
      2: begin
        k = $urandom_range(0, 6);
        r.broadband = 16'd512;
        r.infrared = 16'(sb.seg_bp[sb.package_cs][k] - 1 + $urandom_range(0, 2));
      end
      3: begin
        r.broadband = 16'($urandom_range(0, 15));
        r.infrared = 16'($urandom_range(0, 15));
      end
      default: begin
        r.broadband = 16'($urandom_range(1, lim));
        ratio = $urandom_range(0, 720);
        r.infrared = ((r.broadband * ratio) / 512 > lim) ? lim :
                                                           16'((r.broadband * ratio) / 512);
      end
    endcase
    return r;
  endfunction

  initial begin
    counts_t req;
    int      burst_left, gap;
    bit      no_gaps;
    bit [1:0] fixed_cfg [6][3] = '{'{2'd0, 2'd0, 2'd0}, '{2'd0, 2'd1, 2'd1},
                                   '{2'd1, 2'd0, 2'd1}, '{2'd1, 2'd1, 2'd0},
                                   '{2'd2, 2'd1, 2'd1}, '{2'd3, 2'd0, 2'd1}};
    bit [15:0] directed [8][2] = '{'{16'd0, 16'd0}, '{16'hFFFF, 16'hFFFF},
                                   '{16'd65000, 16'd0}, '{16'd65001, 16'd0},
                                   '{16'd0, 16'd65001}, '{16'd0, 16'd65000},
                                   '{16'd0, 16'd1}, '{16'hAAAA, 16'h5555}};
    bit [15:0] ratio_points [14] = '{16'd64, 16'd65, 16'd128, 16'd129, 16'd192, 16'd193,
                                     16'd256, 16'd257, 16'd312, 16'd313, 16'd410, 16'd411,
                                     16'd666, 16'd667};
    sb = new();
    rst_ni = 1'b0;
    light_if.valid = 1'b0;
    light_if.broadband_count = '0;
    light_if.infrared_count = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // extremes, clipping edges and segment breakpoints with reset settings
    foreach (directed[i]) push_counts(directed[i][0], directed[i][1]);
    foreach (ratio_points[i]) push_counts(16'd512, ratio_points[i]);

    for (int p = 0; p < PHASES; p++) begin
      drain_lux();
      if (p < 6)
        program_regs(fixed_cfg[p][0], fixed_cfg[p][1], fixed_cfg[p][2]);
      else
        program_regs(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                     2'($urandom_range(0, 3)));
      no_gaps = (p % 4 == 1);
      burst_left = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 3 && n == 45) drain_lux();
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap = no_gaps ? 0 : $urandom_range(0, 10);
          pause_light(gap);
        end
        req = random_counts();
        push_counts(req.broadband, req.infrared);
        burst_left--;
      end
    end

    drain_lux();
    repeat (30) @(posedge clk_i);
    if (sb.pending_lux.size() != 0) sb.errors++;
    if (sb.errors == 0)
      $display("lux_from_light_channels: match");
    else
      $display("lux_from_light_channels: mismatch");
    $finish;
  end
endmodule
